[hw/rtl/can_precondition_gateway_controller_macros.svh]
// Assertion macros for the CAN precondition gateway controller.
`ifndef CAN_PRECONDITION_GATEWAY_CONTROLLER_MACROS_SVH
`define CAN_PRECONDITION_GATEWAY_CONTROLLER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define CPGC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define CPGC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cpgc_pkg.sv]
// Types, constants and the button table of the CAN precondition gateway controller.
package cpgc_pkg;

  localparam int unsigned BUTTON_COUNT_DEF = 19;
  localparam int unsigned START_BURST_DEF  = 6;
  localparam int unsigned STOP_BURST_DEF   = 6;
  localparam int unsigned BTN_TABLE_LEN    = 19;

  localparam logic [28:0] CMD_ID    = 29'h0C7;
  localparam logic [28:0] NAV_ID    = 29'h4ED;
  localparam logic [28:0] DIST_ID   = 29'h4E8;
  localparam logic [28:0] INFO_ID   = 29'h4CC;
  localparam logic [28:0] STAT_ID_A = 29'h2AD;
  localparam logic [28:0] STAT_ID_B = 29'h0A82AA03;

  localparam logic [7:0] STAT_MASK   = 8'h1F;
  localparam logic [7:0] ST_IDLE     = 8'h01;
  localparam logic [7:0] ST_STARTING = 8'h05;
  localparam logic [7:0] ST_STARTED  = 8'h15;

  localparam logic [7:0] BURST_A_B3 = 8'h40;
  localparam logic [7:0] BURST_A_B4 = 8'h03;
  localparam logic [7:0] BURST_B_B3 = 8'hE0;
  localparam logic [7:0] BURST_B_B4 = 8'h07;

  // floor(n / 15625) for n < 2^26 as (n * SECS_RECIP) >> SECS_SHIFT
  localparam logic [26:0] SECS_RECIP = 27'd70368745;
  localparam int unsigned SECS_SHIFT = 40;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_FWD  = 2'd1,
    OP_TICK = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    VERDICT_PASS   = 2'd0,
    VERDICT_BLOCK  = 2'd1,
    VERDICT_MODIFY = 2'd2
  } verdict_e;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_TX      = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    REG_BUTTON_ENABLE = 3'd0,
    REG_BUTTON_INDEX  = 3'd1,
    REG_ONCE_MODE     = 3'd2,
    REG_DEBOUNCE_US   = 3'd3,
    REG_RETRY_US      = 3'd4,
    REG_STARTED_TO_US = 3'd5,
    REG_MAX_RETRIES   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [10:0] id;
    logic [2:0]  byte_no;
    logic [7:0]  mask;
    logic [7:0]  value;
  } btn_t;

  typedef struct packed {
    logic        requested;
    logic [31:0] request_time;
    logic [31:0] attempt_time;
    logic [2:0]  start_left;
    logic [2:0]  stop_left;
    logic [2:0]  retry_count;
    logic        starting_seen;
    logic        started_seen;
    logic        stop_seen;
    logic        button_was_pressed;
    logic        status_known;
  } ctl_state_t;

  localparam ctl_state_t CTL_STATE_RESET = '{
    requested:          1'b0,
    request_time:       32'd0,
    attempt_time:       32'd0,
    start_left:         3'd0,
    stop_left:          3'd0,
    retry_count:        3'd0,
    starting_seen:      1'b0,
    started_seen:       1'b0,
    stop_seen:          1'b1,
    button_was_pressed: 1'b0,
    status_known:       1'b0
  };

  function automatic btn_t btn_lookup(logic [4:0] idx);
    btn_t b;
    case (idx)
      5'd0:    b = '{11'h448, 3'd5, 8'hF0, 8'h10};
      5'd1:    b = '{11'h652, 3'd1, 8'h0F, 8'h04};
      5'd2:    b = '{11'h651, 3'd3, 8'hF0, 8'h40};
      5'd3:    b = '{11'h651, 3'd1, 8'hF0, 8'h40};
      5'd4:    b = '{11'h448, 3'd2, 8'hF0, 8'h40};
      5'd5:    b = '{11'h448, 3'd2, 8'h0F, 8'h01};
      5'd6:    b = '{11'h448, 3'd2, 8'h0F, 8'h04};
      5'd7:    b = '{11'h448, 3'd3, 8'h0F, 8'h01};
      5'd8:    b = '{11'h448, 3'd4, 8'h0F, 8'h01};
      5'd9:    b = '{11'h448, 3'd3, 8'hF0, 8'h40};
      5'd10:   b = '{11'h448, 3'd3, 8'hF0, 8'h10};
      5'd11:   b = '{11'h448, 3'd3, 8'h0F, 8'h04};
      5'd12:   b = '{11'h448, 3'd6, 8'hF0, 8'h10};
      5'd13:   b = '{11'h652, 3'd0, 8'hF0, 8'h40};
      5'd14:   b = '{11'h652, 3'd0, 8'hF0, 8'h10};
      5'd15:   b = '{11'h652, 3'd0, 8'h0F, 8'h01};
      5'd16:   b = '{11'h652, 3'd3, 8'h0F, 8'h04};
      5'd17:   b = '{11'h652, 3'd3, 8'h0F, 8'h01};
      5'd18:   b = '{11'h652, 3'd1, 8'h0F, 8'h0D};
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/can_precondition_gateway_controller.sv]
// An input transfer passes the input register, the compute stage and the result register to its result transfer.
// Throughput: one item per cycle unless the result stream stalls; the single compute stage sets it.
// Items that cause no result (frames, quiet ticks, unknown opcodes) still take that one stage.
// Reset (rst_ni low, asynchronous): all control state, stream valids and configuration
// registers return to their defaults at once; no clearing pass.
`include "can_precondition_gateway_controller_macros.svh"

module can_precondition_gateway_controller #(
  parameter int unsigned BUTTON_COUNT = cpgc_pkg::BUTTON_COUNT_DEF,
  parameter int unsigned START_BURST  = cpgc_pkg::START_BURST_DEF,
  parameter int unsigned STOP_BURST   = cpgc_pkg::STOP_BURST_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // can_id[28:0], on_car_bus[29], frame_data[93:30], time_us[125:94], zero[127:126]
  input  logic [127:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // verdict[1:0], out_data[65:2], zero[71:66]
  output logic [71:0]  m_axis_tdata,
  // result_kind[0]
  output logic [0:0]   m_axis_tuser,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [2:0] START_LOAD = 3'(START_BURST);
  localparam logic [2:0] STOP_LOAD  = 3'(STOP_BURST);
  localparam logic [2:0] START_HALF = 3'(START_BURST / 2);
  localparam logic [2:0] STOP_HALF  = 3'(STOP_BURST / 2);
  localparam logic [5:0] BTN_LIMIT  = 6'(BUTTON_COUNT);
  localparam logic [5:0] TABLE_LIMIT = 6'(cpgc_pkg::BTN_TABLE_LEN);

  // ---------------- configuration registers ----------------
  logic        btn_en_q;
  logic [4:0]  btn_idx_q;
  logic        once_q;
  logic [31:0] debounce_q;
  logic [31:0] retry_q;
  logic [31:0] sto_q;
  logic [2:0]  max_retries_q;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_en_q      <= 1'b0;
      btn_idx_q     <= 5'd0;
      once_q        <= 1'b0;
      debounce_q    <= 32'd1000000;
      retry_q       <= 32'd10000000;
      sto_q         <= 32'd70000000;
      max_retries_q <= 3'd4;
    end else if (cfg_wr) begin
      case (reg_idx)
        cpgc_pkg::REG_BUTTON_ENABLE: btn_en_q      <= pwdata[0];
        cpgc_pkg::REG_BUTTON_INDEX:  btn_idx_q     <= pwdata[4:0];
        cpgc_pkg::REG_ONCE_MODE:     once_q        <= pwdata[0];
        cpgc_pkg::REG_DEBOUNCE_US:   debounce_q    <= pwdata;
        cpgc_pkg::REG_RETRY_US:      retry_q       <= pwdata;
        cpgc_pkg::REG_STARTED_TO_US: sto_q         <= pwdata;
        cpgc_pkg::REG_MAX_RETRIES:   max_retries_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cpgc_pkg::REG_BUTTON_ENABLE: prdata = {31'd0, btn_en_q};
      cpgc_pkg::REG_BUTTON_INDEX:  prdata = {27'd0, btn_idx_q};
      cpgc_pkg::REG_ONCE_MODE:     prdata = {31'd0, once_q};
      cpgc_pkg::REG_DEBOUNCE_US:   prdata = debounce_q;
      cpgc_pkg::REG_RETRY_US:      prdata = retry_q;
      cpgc_pkg::REG_STARTED_TO_US: prdata = sto_q;
      cpgc_pkg::REG_MAX_RETRIES:   prdata = {29'd0, max_retries_q};
      default:                     prdata = 32'd0;
    endcase
  end

  // ---------------- input register ----------------
  logic        in_valid_q;
  logic [1:0]  in_op_q;
  logic [28:0] in_id_q;
  logic        in_car_q;
  logic [63:0] in_data_q;
  logic [31:0] in_time_q;
  logic        fire;

  assign fire          = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser;
      in_id_q   <= s_axis_tdata[28:0];
      in_car_q  <= s_axis_tdata[29];
      in_data_q <= s_axis_tdata[93:30];
      in_time_q <= s_axis_tdata[125:94];
    end
  end

  // ---------------- compute stage ----------------
  cpgc_pkg::ctl_state_t st_q, st_d;
  cpgc_pkg::btn_t       btn;
  logic [31:0] elapsed;
  logic [31:0] since_req;
  logic [31:0] disp_limit;
  logic [31:0] disp_diff;
  logic [52:0] div_prod;
  logic [15:0] whole;
  logic [7:0]  stat_byte;
  logic [7:0]  btn_byte;
  logic        is_status;
  logic        btn_active;
  logic        pressed;
  logic        res_valid;
  logic        res_kind;
  logic [1:0]  res_verdict;
  logic [63:0] res_data;
  logic [3:0]  tenths;
  logic [3:0]  unit;
  logic [3:0]  flag;

  assign elapsed   = in_time_q - st_q.attempt_time;
  assign since_req = in_time_q - st_q.request_time;
  assign stat_byte = in_data_q[15:8] & cpgc_pkg::STAT_MASK;
  assign is_status = (in_id_q == cpgc_pkg::STAT_ID_A || in_id_q == cpgc_pkg::STAT_ID_B)
                     && in_car_q;
  assign btn        = cpgc_pkg::btn_lookup(btn_idx_q);
  assign btn_active = btn_en_q && ({1'b0, btn_idx_q} < BTN_LIMIT)
                      && ({1'b0, btn_idx_q} < TABLE_LIMIT);
  assign btn_byte   = 8'(in_data_q >> {btn.byte_no, 3'b000});
  assign pressed    = (btn_byte & btn.mask) == btn.value;

  // whole seconds left on the display; 1e6 = 64 * 15625
  assign disp_limit = (st_q.requested && !st_q.started_seen) ? sto_q : retry_q;
  assign disp_diff  = disp_limit - elapsed;
  assign div_prod   = 53'(disp_diff[31:6]) * 53'(cpgc_pkg::SECS_RECIP);
  assign whole      = (elapsed >= disp_limit) ? 16'd0
                      : 16'(div_prod[52:cpgc_pkg::SECS_SHIFT]);

  always_comb begin
    st_d        = st_q;
    res_valid   = 1'b0;
    res_kind    = cpgc_pkg::KIND_VERDICT;
    res_verdict = cpgc_pkg::VERDICT_PASS;
    res_data    = in_data_q;
    tenths      = 4'd0;
    unit        = 4'd0;
    flag        = 4'd0;
    case (in_op_q)
      cpgc_pkg::OP_RX: begin
        if (is_status) begin
          st_d.status_known = 1'b1;
          if (st_d.requested && !st_d.starting_seen &&
              (stat_byte == cpgc_pkg::ST_STARTING || stat_byte == cpgc_pkg::ST_STARTED))
            st_d.starting_seen = 1'b1;
          if (st_d.requested && !st_d.started_seen && stat_byte == cpgc_pkg::ST_STARTED)
            st_d.started_seen = 1'b1;
          if (st_d.requested && st_d.started_seen) begin
            if (stat_byte == cpgc_pkg::ST_STARTING) begin
              st_d.attempt_time = in_time_q;
              st_d.started_seen = 1'b0;
            end else if (stat_byte == cpgc_pkg::ST_IDLE) begin
              st_d.requested    = 1'b0;
              st_d.attempt_time = in_time_q;
              st_d.retry_count  = 3'd0;
              // without once mode the car stopped by itself: nothing to send
              st_d.stop_left    = once_q ? STOP_LOAD : 3'd0;
              st_d.stop_seen    = !once_q;
            end
          end
          if (!st_d.requested && !st_d.stop_seen && st_d.stop_left == 3'd0 &&
              stat_byte == cpgc_pkg::ST_IDLE)
            st_d.stop_seen = 1'b1;
        end
        if (btn_active && in_id_q == {18'd0, btn.id}) begin
          if (pressed && !st_d.button_was_pressed) begin
            if (!st_d.requested) begin
              st_d.requested     = 1'b1;
              st_d.request_time  = in_time_q;
              st_d.attempt_time  = in_time_q;
              st_d.start_left    = START_LOAD;
              st_d.starting_seen = 1'b0;
              st_d.started_seen  = 1'b0;
              st_d.retry_count   = 3'd0;
            end else if (since_req > debounce_q) begin
              st_d.requested    = 1'b0;
              st_d.attempt_time = in_time_q;
              st_d.stop_left    = STOP_LOAD;
              st_d.stop_seen    = 1'b0;
              st_d.retry_count  = 3'd0;
            end
          end
          st_d.button_was_pressed = pressed;
        end
      end
      cpgc_pkg::OP_FWD: begin
        res_valid = 1'b1;
        if (!in_car_q) begin
          res_verdict = cpgc_pkg::VERDICT_PASS;
        end else if (st_q.requested && in_id_q == cpgc_pkg::CMD_ID) begin
          res_verdict = cpgc_pkg::VERDICT_BLOCK;
        end else if (st_q.requested && in_id_q == cpgc_pkg::NAV_ID) begin
          res_data[47:40] = 8'h10;
          res_data[55:48] = 8'hA0;
          res_data[63:56] = 8'h00;
          res_verdict     = cpgc_pkg::VERDICT_MODIFY;
        end else if (st_q.requested && !st_q.started_seen &&
                     in_id_q == cpgc_pkg::DIST_ID) begin
          tenths = st_q.status_known ? {1'b0, st_q.retry_count} : 4'd0;
          unit   = !st_q.status_known ? 4'd0 : (st_q.retry_count == 3'd0) ? 4'd4 : 4'd1;
          flag   = !st_q.status_known ? 4'd4 : st_q.starting_seen ? 4'd0 : 4'd1;
          res_data[7:0]   = {tenths, unit};
          res_data[47:32] = whole;
          res_data[51:48] = flag;
          res_verdict     = cpgc_pkg::VERDICT_MODIFY;
        end else if (st_q.requested && !st_q.started_seen &&
                     in_id_q == cpgc_pkg::INFO_ID) begin
          res_data[7:0] = 8'h02;
          res_verdict   = cpgc_pkg::VERDICT_MODIFY;
        end else if (!st_q.requested && st_q.status_known && !st_q.stop_seen &&
                     st_q.retry_count < max_retries_q) begin
          if (in_id_q == cpgc_pkg::DIST_ID) begin
            // retry count stays below ten, so it is its own tenths digit
            tenths = {1'b0, st_q.retry_count};
            unit   = (st_q.retry_count == 3'd0) ? 4'd3 : 4'd2;
            flag   = 4'hF;
            res_data[7:0]   = {tenths, unit};
            res_data[47:32] = whole;
            res_data[51:48] = flag;
            res_verdict     = cpgc_pkg::VERDICT_MODIFY;
          end else if (in_id_q == cpgc_pkg::INFO_ID) begin
            res_data[7:0] = 8'h02;
            res_verdict   = cpgc_pkg::VERDICT_MODIFY;
          end
        end
      end
      cpgc_pkg::OP_TICK: begin
        if (st_d.status_known) begin
          if (st_d.requested && st_d.start_left == 3'd0 &&
              st_d.retry_count >= max_retries_q &&
              ((!st_d.starting_seen && elapsed > retry_q) ||
               (!st_d.started_seen && elapsed > sto_q))) begin
            st_d.requested    = 1'b0;
            st_d.attempt_time = in_time_q;
            st_d.stop_left    = STOP_LOAD;
            st_d.stop_seen    = 1'b0;
            st_d.retry_count  = max_retries_q;
          end
          if (st_d.requested && !st_d.starting_seen && st_d.start_left == 3'd0 &&
              st_d.retry_count < max_retries_q && elapsed > retry_q) begin
            st_d.attempt_time = in_time_q;
            st_d.start_left   = START_LOAD;
            st_d.retry_count  = st_d.retry_count + 3'd1;
          end
          if (st_d.requested && !st_d.started_seen && st_d.start_left == 3'd0 &&
              st_d.retry_count < max_retries_q && elapsed > sto_q) begin
            st_d.attempt_time = in_time_q;
            st_d.start_left   = START_LOAD;
            st_d.retry_count  = st_d.retry_count + 3'd1;
          end
          if (!st_d.requested && !st_d.stop_seen && st_d.stop_left == 3'd0 &&
              st_d.retry_count < max_retries_q && elapsed > retry_q) begin
            st_d.attempt_time = in_time_q;
            st_d.stop_left    = STOP_LOAD;
            st_d.retry_count  = st_d.retry_count + 3'd1;
          end
        end else if (st_d.requested && elapsed > sto_q) begin
          st_d.started_seen = 1'b1;
        end
        res_data = 64'd0;
        res_kind = cpgc_pkg::KIND_TX;
        if (st_d.requested && st_d.start_left != 3'd0) begin
          res_valid = 1'b1;
          if (st_d.start_left > START_HALF) begin
            res_data[31:24] = cpgc_pkg::BURST_A_B3;
            res_data[39:32] = cpgc_pkg::BURST_A_B4;
          end else begin
            res_data[31:24] = cpgc_pkg::BURST_B_B3;
            res_data[39:32] = cpgc_pkg::BURST_B_B4;
          end
          st_d.start_left = st_d.start_left - 3'd1;
        end else if (!st_d.requested && st_d.stop_left != 3'd0) begin
          res_valid = 1'b1;
          if (st_d.stop_left <= STOP_HALF) begin
            res_data[31:24] = cpgc_pkg::BURST_B_B3;
            res_data[39:32] = cpgc_pkg::BURST_B_B4;
          end
          st_d.stop_left = st_d.stop_left - 3'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cpgc_pkg::CTL_STATE_RESET;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  // ---------------- result register ----------------
  logic        out_valid_q;
  logic        out_kind_q;
  logic [1:0]  out_verdict_q;
  logic [63:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_kind_q    <= res_kind;
      out_verdict_q <= res_verdict;
      out_data_q    <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q, out_verdict_q};
  assign m_axis_tuser  = out_kind_q;

  // ---------------- assertions ----------------
  `CPGC_ASSERT_IMP(a_tx_no_verdict, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[1:0] == 2'd0, "burst frame carries a verdict")
  `CPGC_ASSERT_IMP(a_tx_low_bytes, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[25:2] == 24'd0, "burst frame bytes 0 to 2 not zero")
  `CPGC_ASSERT_IMP(a_verdict_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "undefined verdict code")
  `CPGC_ASSERT_IMP(a_burst_bound, 1'b1, st_q.start_left <= START_LOAD && st_q.stop_left <= STOP_LOAD, "burst counter past its load")
  `CPGC_ASSERT_NXT(a_stall_holds_state, in_valid_q && !fire, $stable(st_q), "state moved without a transfer")

endmodule

[sim/can_precondition_gateway_controller_tb.sv]
// Self-checking stream testbench for the CAN precondition gateway controller.
module can_precondition_gateway_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned ITEMS_PER_PHASE = 110;
  localparam int unsigned PHASES = 7;

  // display codes written into the distance frame
  localparam logic [3:0] UNIT_START_FIRST = 4'd4;
  localparam logic [3:0] UNIT_START_RETRY = 4'd1;
  localparam logic [3:0] UNIT_STOP_FIRST  = 4'd3;
  localparam logic [3:0] UNIT_STOP_RETRY  = 4'd2;
  localparam logic [3:0] FLAG_CONFIRMED   = 4'd0;
  localparam logic [3:0] FLAG_WAITING     = 4'd1;
  localparam logic [3:0] FLAG_NO_STATUS   = 4'd4;
  localparam logic [3:0] FLAG_STOPPING    = 4'hF;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [28:0] id;
    logic        car;
    logic [63:0] data;
    logic [31:0] stamp;
  } can_item_t;

  typedef struct packed {
    cpgc_pkg::kind_e    kind;
    cpgc_pkg::verdict_e verdict;
    logic [63:0]        payload;
  } can_out_t;

  // activation button patterns: id, byte, mask, value
  localparam cpgc_pkg::btn_t BUTTON_PATTERNS [cpgc_pkg::BTN_TABLE_LEN] = '{
    {11'h448, 3'd5, 8'hF0, 8'h10}, {11'h652, 3'd1, 8'h0F, 8'h04},
    {11'h651, 3'd3, 8'hF0, 8'h40}, {11'h651, 3'd1, 8'hF0, 8'h40},
    {11'h448, 3'd2, 8'hF0, 8'h40}, {11'h448, 3'd2, 8'h0F, 8'h01},
    {11'h448, 3'd2, 8'h0F, 8'h04}, {11'h448, 3'd3, 8'h0F, 8'h01},
    {11'h448, 3'd4, 8'h0F, 8'h01}, {11'h448, 3'd3, 8'hF0, 8'h40},
    {11'h448, 3'd3, 8'hF0, 8'h10}, {11'h448, 3'd3, 8'h0F, 8'h04},
    {11'h448, 3'd6, 8'hF0, 8'h10}, {11'h652, 3'd0, 8'hF0, 8'h40},
    {11'h652, 3'd0, 8'hF0, 8'h10}, {11'h652, 3'd0, 8'h0F, 8'h01},
    {11'h652, 3'd3, 8'h0F, 8'h04}, {11'h652, 3'd3, 8'h0F, 8'h01},
    {11'h652, 3'd1, 8'h0F, 8'h0D}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  can_item_t can_item = '0;
  can_item_t can_items_todo[$];
  can_out_t  due_outputs[$];

  logic        in_fire = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned rx_count = 0;
  rx_pattern_e rx_mode = RX_ALWAYS;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  // stimulus state
  logic [31:0] bus_time = '0;
  logic [31:0] tick_base = 32'd40000;
  logic [4:0]  gen_btn_idx = '0;
  logic        press_next = 1'b1;

  // predictor configuration
  logic        cfg_btn_en;
  logic [4:0]  cfg_btn_idx;
  logic        cfg_once;
  logic [31:0] cfg_debounce;
  logic [31:0] cfg_retry;
  logic [31:0] cfg_started_to;
  logic [2:0]  cfg_max_retries;

  // predictor state
  logic        req_active;
  logic [31:0] req_time;
  logic [31:0] attempt_t;
  logic [2:0]  start_left;
  logic [2:0]  stop_left;
  logic [2:0]  retries;
  logic        starting_ok;
  logic        started_ok;
  logic        stop_ok;
  logic        btn_prev;
  logic        status_valid;

  initial begin
    cfg_btn_en = 1'b0;
    cfg_btn_idx = '0;
    cfg_once = 1'b0;
    cfg_debounce = 32'd1000000;
    cfg_retry = 32'd10000000;
    cfg_started_to = 32'd70000000;
    cfg_max_retries = 3'd4;
    req_active = 1'b0;
    req_time = '0;
    attempt_t = '0;
    start_left = '0;
    stop_left = '0;
    retries = '0;
    starting_ok = 1'b0;
    started_ok = 1'b0;
    stop_ok = 1'b1;
    btn_prev = 1'b0;
    status_valid = 1'b0;
  end

  assign s_axis_tdata = {2'b00, can_item.stamp, can_item.data, can_item.car, can_item.id};
  assign s_axis_tuser = can_item.op;

  can_precondition_gateway_controller i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] burst_word(logic [7:0] b3, logic [7:0] b4);
    return {24'd0, b4, b3, 24'd0};
  endfunction

  function automatic logic [31:0] secs_left(logic [31:0] el, logic [31:0] lim);
    return (el >= lim) ? 32'd0 : (lim - el) / 32'd1000000;
  endfunction

  function automatic logic [63:0] show_distance(logic [63:0] d, logic [31:0] whole,
                                                logic [3:0] tenths, logic [3:0] units,
                                                logic [3:0] flag);
    d[7:0]   = {tenths, units};
    d[39:32] = whole[7:0];
    d[47:40] = whole[15:8];
    d[51:48] = flag;
    return d;
  endfunction

  function automatic void start_stop(logic [31:0] t_now);
    req_active = 1'b0;
    attempt_t = t_now;
    stop_left = 3'(cpgc_pkg::STOP_BURST_DEF);
    stop_ok = 1'b0;
    retries = '0;
  endfunction

  function automatic void gateway_step(input can_item_t it, output logic produced,
                                       output can_out_t res);
    logic [31:0]    el;
    logic [4:0]     s;
    logic [63:0]    d;
    cpgc_pkg::btn_t b;
    logic           pressed;
    el = it.stamp - attempt_t;
    d = it.data;
    produced = 1'b0;
    res = '{cpgc_pkg::KIND_VERDICT, cpgc_pkg::VERDICT_PASS, it.data};
    case (it.op)
      cpgc_pkg::OP_RX: begin
        if ((it.id == cpgc_pkg::STAT_ID_A || it.id == cpgc_pkg::STAT_ID_B) && it.car) begin
          s = d[12:8];
          status_valid = 1'b1;
          if (req_active && !starting_ok && ({3'd0, s} == cpgc_pkg::ST_STARTING ||
                                             {3'd0, s} == cpgc_pkg::ST_STARTED))
            starting_ok = 1'b1;
          if (req_active && !started_ok && {3'd0, s} == cpgc_pkg::ST_STARTED)
            started_ok = 1'b1;
          if (req_active && started_ok) begin
            if ({3'd0, s} == cpgc_pkg::ST_STARTING) begin
              attempt_t = it.stamp;
              started_ok = 1'b0;
            end
            if ({3'd0, s} == cpgc_pkg::ST_IDLE) begin
              start_stop(it.stamp);
              // without once mode the car stopping on its own counts as done
              if (!cfg_once) begin
                stop_left = '0;
                stop_ok = 1'b1;
              end
            end
          end
          if (!req_active && !stop_ok && stop_left == 0 && {3'd0, s} == cpgc_pkg::ST_IDLE)
            stop_ok = 1'b1;
        end
        if (cfg_btn_en && cfg_btn_idx < cpgc_pkg::BUTTON_COUNT_DEF &&
            cfg_btn_idx < cpgc_pkg::BTN_TABLE_LEN) begin
          b = BUTTON_PATTERNS[cfg_btn_idx];
          if (it.id == 29'(b.id)) begin
            pressed = (d[{b.byte_no, 3'b000} +: 8] & b.mask) == b.value;
            if (pressed && !btn_prev) begin
              if (!req_active) begin
                req_active = 1'b1;
                req_time = it.stamp;
                attempt_t = it.stamp;
                start_left = 3'(cpgc_pkg::START_BURST_DEF);
                starting_ok = 1'b0;
                started_ok = 1'b0;
                retries = '0;
              end else if (it.stamp - req_time > cfg_debounce) begin
                start_stop(it.stamp);
              end
            end
            btn_prev = pressed;
          end
        end
      end
      cpgc_pkg::OP_FWD: begin
        produced = 1'b1;
        if (it.car) begin
          if (req_active && it.id == cpgc_pkg::CMD_ID) begin
            res.verdict = cpgc_pkg::VERDICT_BLOCK;
          end else if (req_active && it.id == cpgc_pkg::NAV_ID) begin
            d[47:40] = 8'h10;
            d[55:48] = 8'hA0;
            d[63:56] = 8'h00;
            res.verdict = cpgc_pkg::VERDICT_MODIFY;
          end else if (req_active && !started_ok &&
                       (it.id == cpgc_pkg::DIST_ID || it.id == cpgc_pkg::INFO_ID)) begin
            if (it.id == cpgc_pkg::DIST_ID)
              d = show_distance(d, secs_left(el, cfg_started_to),
                                status_valid ? 4'(retries) : 4'd0,
                                !status_valid ? 4'd0 :
                                (retries == 0) ? UNIT_START_FIRST : UNIT_START_RETRY,
                                !status_valid ? FLAG_NO_STATUS :
                                starting_ok ? FLAG_CONFIRMED : FLAG_WAITING);
            else
              d[7:0] = 8'h02;
            res.verdict = cpgc_pkg::VERDICT_MODIFY;
          end else if (!req_active && status_valid && !stop_ok && retries < cfg_max_retries &&
                       (it.id == cpgc_pkg::DIST_ID || it.id == cpgc_pkg::INFO_ID)) begin
            if (it.id == cpgc_pkg::DIST_ID)
              d = show_distance(d, secs_left(el, cfg_retry), 4'(retries),
                                (retries == 0) ? UNIT_STOP_FIRST : UNIT_STOP_RETRY,
                                FLAG_STOPPING);
            else
              d[7:0] = 8'h02;
            res.verdict = cpgc_pkg::VERDICT_MODIFY;
          end
        end
        res.payload = d;
      end
      cpgc_pkg::OP_TICK: begin
        if (status_valid) begin
          // out of retries: give up and switch to stopping
          if (req_active && start_left == 0 && retries >= cfg_max_retries &&
              ((!starting_ok && el > cfg_retry) || (!started_ok && el > cfg_started_to))) begin
            start_stop(it.stamp);
            retries = cfg_max_retries;
          end
          if (req_active && !starting_ok && start_left == 0 && retries < cfg_max_retries &&
              el > cfg_retry) begin
            attempt_t = it.stamp;
            start_left = 3'(cpgc_pkg::START_BURST_DEF);
            retries = retries + 3'd1;
          end
          if (req_active && !started_ok && start_left == 0 && retries < cfg_max_retries &&
              el > cfg_started_to) begin
            attempt_t = it.stamp;
            start_left = 3'(cpgc_pkg::START_BURST_DEF);
            retries = retries + 3'd1;
          end
          if (!req_active && !stop_ok && stop_left == 0 && retries < cfg_max_retries &&
              el > cfg_retry) begin
            attempt_t = it.stamp;
            stop_left = 3'(cpgc_pkg::STOP_BURST_DEF);
            retries = retries + 3'd1;
          end
        end else if (req_active && el > cfg_started_to) begin
          started_ok = 1'b1;
        end
        res.kind = cpgc_pkg::KIND_TX;
        if (req_active && start_left != 0) begin
          res.payload = (start_left > cpgc_pkg::START_BURST_DEF / 2)
                        ? burst_word(cpgc_pkg::BURST_A_B3, cpgc_pkg::BURST_A_B4)
                        : burst_word(cpgc_pkg::BURST_B_B3, cpgc_pkg::BURST_B_B4);
          start_left = start_left - 3'd1;
          produced = 1'b1;
        end else if (!req_active && stop_left != 0) begin
          res.payload = (stop_left <= cpgc_pkg::STOP_BURST_DEF / 2)
                        ? burst_word(cpgc_pkg::BURST_B_B3, cpgc_pkg::BURST_B_B4)
                        : 64'd0;
          stop_left = stop_left - 3'd1;
          produced = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(cpgc_pkg::reg_idx_e idx);
    case (idx)
      cpgc_pkg::REG_BUTTON_ENABLE: return {31'd0, cfg_btn_en};
      cpgc_pkg::REG_BUTTON_INDEX:  return {27'd0, cfg_btn_idx};
      cpgc_pkg::REG_ONCE_MODE:     return {31'd0, cfg_once};
      cpgc_pkg::REG_DEBOUNCE_US:   return cfg_debounce;
      cpgc_pkg::REG_RETRY_US:      return cfg_retry;
      cpgc_pkg::REG_STARTED_TO_US: return cfg_started_to;
      cpgc_pkg::REG_MAX_RETRIES:   return {29'd0, cfg_max_retries};
      default:                     return '0;
    endcase
  endfunction

  function automatic void apply_reg_write(cpgc_pkg::reg_idx_e idx, logic [31:0] val);
    case (idx)
      cpgc_pkg::REG_BUTTON_ENABLE: cfg_btn_en = val[0];
      cpgc_pkg::REG_BUTTON_INDEX:  cfg_btn_idx = val[4:0];
      cpgc_pkg::REG_ONCE_MODE:     cfg_once = val[0];
      cpgc_pkg::REG_DEBOUNCE_US:   cfg_debounce = val;
      cpgc_pkg::REG_RETRY_US:      cfg_retry = val;
      cpgc_pkg::REG_STARTED_TO_US: cfg_started_to = val;
      cpgc_pkg::REG_MAX_RETRIES:   cfg_max_retries = val[2:0];
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------- driver and monitor

  always @(negedge clk_i) begin
    can_item_t nxt;
    logic      v_next;
    logic      rdy_next;
    v_next = s_axis_tvalid;
    if (!rst_ni) begin
      v_next = 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      v_next = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (can_items_todo.size() != 0) begin
        nxt = can_items_todo.pop_front();
        can_item <= nxt;
        v_next = 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    s_axis_tvalid <= v_next;

    rx_count++;
    if (rx_count % 50 == 0) rx_mode = rx_pattern_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS: rdy_next = 1'b1;
      RX_COIN:   rdy_next = 1'($urandom_range(0, 1));
      RX_SPARSE: rdy_next = ($urandom_range(0, 3) == 0);
      default:   rdy_next = (rx_count % 8) < 5;
    endcase
    m_axis_tready <= rdy_next;
  end

  always @(posedge clk_i) begin
    can_out_t want;
    logic     produced;
    in_fire <= s_axis_tvalid && s_axis_tready;
    cycle_count++;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_outputs.size() == 0) begin
          $error("unexpected result transfer: kind %0d tdata %h", m_axis_tuser[0], m_axis_tdata);
          error_count++;
        end else begin
          want = due_outputs.pop_front();
          if (m_axis_tuser[0] !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, m_axis_tuser[0]);
            error_count++;
          end
          if (m_axis_tdata[1:0] !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, m_axis_tdata[1:0]);
            error_count++;
          end
          if (m_axis_tdata[65:2] !== want.payload) begin
            $error("out_data: expected %h, got %h", want.payload, m_axis_tdata[65:2]);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        gateway_step(can_item, produced, want);
        if (produced) due_outputs.push_back(want);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          apply_reg_write(cpgc_pkg::reg_idx_e'(paddr[4:2]), pwdata);
        end else if (prdata !== reg_value(cpgc_pkg::reg_idx_e'(paddr[4:2]))) begin
          $error("register %0d readback: expected %h, got %h", paddr[4:2],
                 reg_value(cpgc_pkg::reg_idx_e'(paddr[4:2])), prdata);
          error_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("can_precondition_gateway_controller_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void push_item(logic [1:0] op, logic [28:0] id, logic car,
                                    logic [63:0] data, logic [31:0] dt);
    can_item_t it;
    bus_time = bus_time + dt;
    it.op = op;
    it.id = id;
    it.car = car;
    it.data = data;
    it.stamp = bus_time;
    can_items_todo.push_back(it);
  endfunction

  function automatic void push_random_item();
    int unsigned    pick;
    logic [63:0]    d;
    logic [28:0]    id;
    logic [4:0]     stat;
    logic [7:0]     bval;
    cpgc_pkg::btn_t b;
    d = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // mostly about one tick period, now and then a jump anywhere
      push_item(cpgc_pkg::OP_TICK, 29'($urandom()), 1'($urandom_range(0, 1)), d,
                ($urandom_range(0, 49) == 0) ? $urandom() :
                tick_base - (tick_base >> 3) + $urandom_range(0, tick_base >> 2));
    end else if (pick < 52) begin
      case ($urandom_range(0, 4))
        0: stat = 5'(cpgc_pkg::ST_IDLE);
        1: stat = 5'(cpgc_pkg::ST_STARTING);
        2: stat = 5'(cpgc_pkg::ST_STARTED);
        3: stat = 5'(cpgc_pkg::ST_STARTED);
        default: stat = 5'($urandom());
      endcase
      d[15:8] = {3'($urandom()), stat};
      id = $urandom_range(0, 1) ? cpgc_pkg::STAT_ID_A : cpgc_pkg::STAT_ID_B;
      push_item(cpgc_pkg::OP_RX, id, $urandom_range(0, 9) != 0, d, $urandom_range(0, 2000));
    end else if (pick < 69) begin
      b = BUTTON_PATTERNS[(gen_btn_idx < cpgc_pkg::BTN_TABLE_LEN) ? gen_btn_idx
                          : $urandom_range(0, cpgc_pkg::BTN_TABLE_LEN - 1)];
      bval = d[{b.byte_no, 3'b000} +: 8];
      if (press_next)
        bval = (bval & ~b.mask) | b.value;
      else if ($urandom_range(0, 9) < 8)
        bval = (bval & ~b.mask) | (b.value ^ b.mask);
      d[{b.byte_no, 3'b000} +: 8] = bval;
      if ($urandom_range(0, 9) < 7) press_next = !press_next;
      push_item(cpgc_pkg::OP_RX, 29'(b.id), 1'($urandom_range(0, 1)), d,
                $urandom_range(0, 2000));
    end else if (pick < 94) begin
      case ($urandom_range(0, 6))
        0: id = cpgc_pkg::CMD_ID;
        1: id = cpgc_pkg::NAV_ID;
        2: id = cpgc_pkg::DIST_ID;
        3: id = cpgc_pkg::INFO_ID;
        4: id = cpgc_pkg::DIST_ID;
        5: id = 29'($urandom_range(0, 2047));
        default: id = 29'($urandom());
      endcase
      push_item(cpgc_pkg::OP_FWD, id, $urandom_range(0, 9) != 0, d, $urandom_range(0, 2000));
    end else begin
      push_item(2'($urandom_range(0, 3)), 29'($urandom()), 1'($urandom_range(0, 1)), d,
                $urandom_range(0, 2000));
    end
  endfunction

  task automatic write_reg(cpgc_pkg::reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    // read straight back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // narrow registers get junk in the unused bits
  task automatic configure(logic en, logic [4:0] idx, logic once, logic [31:0] deb,
                           logic [31:0] retry, logic [31:0] started, logic [2:0] maxr);
    write_reg(cpgc_pkg::REG_BUTTON_ENABLE, {31'($urandom()), en});
    write_reg(cpgc_pkg::REG_BUTTON_INDEX, {27'($urandom()), idx});
    write_reg(cpgc_pkg::REG_ONCE_MODE, {31'($urandom()), once});
    write_reg(cpgc_pkg::REG_DEBOUNCE_US, deb);
    write_reg(cpgc_pkg::REG_RETRY_US, retry);
    write_reg(cpgc_pkg::REG_STARTED_TO_US, started);
    write_reg(cpgc_pkg::REG_MAX_RETRIES, {29'($urandom()), maxr});
    gen_btn_idx = idx;
  endtask

  task automatic wait_idle();
    while (can_items_todo.size() != 0 || s_axis_tvalid || due_outputs.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] retry;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: button off, nothing requested
    push_item(cpgc_pkg::OP_TICK, '0, 1'b0, '0, 32'd0);
    push_item(cpgc_pkg::OP_FWD, cpgc_pkg::CMD_ID, 1'b1, '1, 32'd10);
    push_item(cpgc_pkg::OP_FWD, '1, 1'b0, '1, 32'hFFFF_FFFF - bus_time);
    push_item(OP_UNUSED, '1, 1'b1, '1, 32'd1);
    push_item(cpgc_pkg::OP_RX, cpgc_pkg::STAT_ID_B, 1'b1, 64'h0000_0000_0000_E100, 32'd5);
    push_item(cpgc_pkg::OP_FWD, cpgc_pkg::DIST_ID, 1'b1, {$urandom(), $urandom()}, 32'd5);
    wait_idle();

    // one full start run and an active stop, short timings
    configure(1'b1, 5'd0, 1'b1, 32'd50000, 32'd200000, 32'd400000, 3'd2);
    push_item(cpgc_pkg::OP_RX, 29'h448, 1'b0, 64'h0000_1000_0000_0000, 32'd100);
    push_item(cpgc_pkg::OP_FWD, cpgc_pkg::CMD_ID, 1'b1, {$urandom(), $urandom()}, 32'd100);
    push_item(cpgc_pkg::OP_FWD, cpgc_pkg::NAV_ID, 1'b1, '1, 32'd100);
    push_item(cpgc_pkg::OP_FWD, cpgc_pkg::DIST_ID, 1'b1, '1, 32'd100);
    push_item(cpgc_pkg::OP_FWD, cpgc_pkg::INFO_ID, 1'b1, '1, 32'd100);
    repeat (6) push_item(cpgc_pkg::OP_TICK, '0, 1'b1, '0, 32'd1000);
    push_item(cpgc_pkg::OP_RX, cpgc_pkg::STAT_ID_A, 1'b1, 64'h0000_0000_0000_A500, 32'd100);
    push_item(cpgc_pkg::OP_RX, cpgc_pkg::STAT_ID_A, 1'b1, 64'h0000_0000_00FF_3500, 32'd100);
    push_item(cpgc_pkg::OP_RX, cpgc_pkg::STAT_ID_A, 1'b1, 64'h0000_0000_0000_2100, 32'd100);
    repeat (6) push_item(cpgc_pkg::OP_TICK, '0, 1'b1, '0, 32'd1000);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      tick_base = 32'd40000;
      retry = $urandom_range(80000, 400000);
      case (p)
        0: configure(1'b1, 5'd18, 1'b1, '0, '0, '0, 3'd0);
        1: configure(1'b1, 5'd0, 1'b0, '1, '1, '1, 3'd7);
        2: begin
          // reset-value timings, coarse ticks, time wraps during the phase
          tick_base = 32'd1000000;
          bus_time = 32'hFFFF_FFFF - $urandom_range(0, 50000000);
          configure(1'b1, 5'($urandom_range(0, 18)), 1'($urandom_range(0, 1)), 32'd1000000,
                    32'd10000000, 32'd70000000, 3'd4);
        end
        3: configure(1'b1, 5'($urandom_range(19, 31)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 200000), retry, retry + $urandom_range(0, 800000),
                     3'($urandom_range(0, 7)));
        4: configure(1'b0, 5'($urandom_range(0, 18)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 200000), retry, retry + $urandom_range(0, 800000),
                     3'($urandom_range(0, 7)));
        default: configure(1'b1, 5'($urandom_range(0, 18)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 200000), retry,
                           retry + $urandom_range(0, 800000), 3'($urandom_range(0, 7)));
      endcase
      repeat (ITEMS_PER_PHASE) push_random_item();
      wait_idle();
    end

    if (error_count == 0 && due_outputs.size() == 0) begin
      $display("can_precondition_gateway_controller_tb: done, clean");
    end else begin
      $display("can_precondition_gateway_controller_tb: done, errors");
    end
    $finish;
  end

endmodule

[can_precondition_gateway_controller.f]
+incdir+hw/rtl
hw/rtl/cpgc_pkg.sv
hw/rtl/can_precondition_gateway_controller.sv
sim/can_precondition_gateway_controller_tb.sv
